// ----- hdl/gctc_pkg.sv -----
package gctc_pkg;

  localparam int CLASS_W   = 13;
  localparam int PROB_W    = 16;
  localparam int SUM_W     = 27;
  localparam int CNT_W     = 11;
  localparam int MAX_STEPS = 1024;

  // The quotient always fits in PROB_W bits, so only PROB_W divide steps are needed.
  localparam int DIV_STEPS = PROB_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CLASS_W-1:0] KEY_COUNT_RST = CLASS_W'(8191);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } gctc_state_t;

  typedef struct packed {
    logic step;       // transaction accepted this cycle
    logic div_iter;   // one divide step
    logic push_conf;  // push the end-of-sequence result
  } gctc_cmd_t;

  typedef struct packed {
    logic fifo_full;
  } gctc_sts_t;

  typedef struct packed {
    logic               char_valid;
    logic [CLASS_W-1:0] dict_index;
    logic               seq_end;
    logic [PROB_W-1:0]  confidence;
  } gctc_res_t;

endpackage

// ----- hdl/gctc_in_if.sv -----
interface gctc_in_if;
  logic                          valid;
  logic                          ready;
  logic [gctc_pkg::CLASS_W-1:0]  class_index;
  logic [gctc_pkg::PROB_W-1:0]   probability;
  logic                          last_step;

  modport source (output valid, class_index, probability, last_step, input ready);
  modport sink   (input valid, class_index, probability, last_step, output ready);
endinterface

// ----- hdl/gctc_out_if.sv -----
interface gctc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          char_valid;
  logic [gctc_pkg::CLASS_W-1:0]  dict_index;
  logic                          seq_end;
  logic [gctc_pkg::PROB_W-1:0]   confidence;

  modport source (output valid, char_valid, dict_index, seq_end, confidence, input ready);
  modport sink   (input valid, char_valid, dict_index, seq_end, confidence, output ready);
endinterface

// ----- hdl/gctc_ctrl.sv -----
module gctc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  input  gctc_pkg::gctc_sts_t sts,
  output logic                in_ready,
  output gctc_pkg::gctc_cmd_t cmd
);

  gctc_pkg::gctc_state_t state_r, state_nxt;
  logic [gctc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic div_done;

  assign div_done = (cnt_r == gctc_pkg::DIV_CNT_W'(gctc_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gctc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      gctc_pkg::ST_IDLE: begin
        if (in_valid && !sts.fifo_full && in_last) state_nxt = gctc_pkg::ST_DIV;
      end
      gctc_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + gctc_pkg::DIV_CNT_W'(1);
        if (div_done) begin
          state_nxt = gctc_pkg::ST_PUSH;
          cnt_nxt   = '0;
        end
      end
      gctc_pkg::ST_PUSH: begin
        if (!sts.fifo_full) state_nxt = gctc_pkg::ST_IDLE;
      end
      default: state_nxt = gctc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.step      = 1'b0;
    cmd.div_iter  = 1'b0;
    cmd.push_conf = 1'b0;
    case (state_r)
      gctc_pkg::ST_IDLE: begin
        in_ready = !sts.fifo_full;
        cmd.step = in_valid && !sts.fifo_full;
      end
      gctc_pkg::ST_DIV:  cmd.div_iter  = 1'b1;
      gctc_pkg::ST_PUSH: cmd.push_conf = !sts.fifo_full;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ----- hdl/gctc_dp.sv -----
module gctc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gctc_pkg::CLASS_W-1:0]  cfg_wdata,
  input  logic [gctc_pkg::CLASS_W-1:0]  class_index,
  input  logic [gctc_pkg::PROB_W-1:0]   probability,
  input  logic                          last_step,
  input  gctc_pkg::gctc_cmd_t           cmd,
  output gctc_pkg::gctc_sts_t           sts,
  output logic                          res_valid,
  input  logic                          res_ready,
  output gctc_pkg::gctc_res_t           res
);

  logic [gctc_pkg::CLASS_W-1:0] key_count_r;
  logic [gctc_pkg::CLASS_W-1:0] prev_r;
  logic [gctc_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [gctc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // divider
  logic [gctc_pkg::CNT_W-1:0]   rem_r, div_r;
  logic [gctc_pkg::PROB_W-1:0]  quo_r;
  logic                         zero_r;
  logic                         last_char_r;
  logic [gctc_pkg::CLASS_W-1:0] last_key_r;
  logic [gctc_pkg::CNT_W:0]     trial;
  logic [gctc_pkg::CNT_W:0]     diff;
  logic                         qbit;

  logic                         emit;
  logic [gctc_pkg::CLASS_W-1:0] key;

  // result queue, two entries
  gctc_pkg::gctc_res_t q_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    qcnt_r;
  logic          push, pop;
  gctc_pkg::gctc_res_t push_data;

  always_comb begin
    key  = class_index - gctc_pkg::CLASS_W'(1);
    emit = (class_index != '0) && (class_index != prev_r) && (key < key_count_r);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (emit && (cnt_r < gctc_pkg::CNT_W'(gctc_pkg::MAX_STEPS))) begin
      sum_nxt = sum_r + gctc_pkg::SUM_W'(probability);
      cnt_nxt = cnt_r + gctc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= gctc_pkg::KEY_COUNT_RST;
      prev_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) key_count_r <= cfg_wdata;
      if (cmd.step) begin
        if (last_step) begin
          prev_r <= '0;
          sum_r  <= '0;
          cnt_r  <= '0;
        end else begin
          prev_r <= class_index;
          sum_r  <= sum_nxt;
          cnt_r  <= cnt_nxt;
        end
      end
    end
  end

  // restoring divide; upper sum bits start as remainder since quotient < 2^PROB_W
  assign trial = {rem_r, quo_r[gctc_pkg::PROB_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign qbit  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (cmd.step && last_step) begin
      rem_r       <= sum_nxt[gctc_pkg::SUM_W-1:gctc_pkg::PROB_W];
      quo_r       <= sum_nxt[gctc_pkg::PROB_W-1:0];
      div_r       <= cnt_nxt;
      zero_r      <= (cnt_nxt == '0);
      last_char_r <= emit;
      last_key_r  <= emit ? key : '0;
    end else if (cmd.div_iter) begin
      rem_r <= qbit ? diff[gctc_pkg::CNT_W-1:0] : trial[gctc_pkg::CNT_W-1:0];
      quo_r <= {quo_r[gctc_pkg::PROB_W-2:0], qbit};
    end
  end

  always_comb begin
    push = (cmd.step && !last_step) || cmd.push_conf;
    if (cmd.push_conf) begin
      push_data.char_valid = last_char_r;
      push_data.dict_index = last_key_r;
      push_data.seq_end    = 1'b1;
      push_data.confidence = zero_r ? '0 : quo_r;
    end else begin
      push_data.char_valid = emit;
      push_data.dict_index = emit ? key : '0;
      push_data.seq_end    = 1'b0;
      push_data.confidence = '0;
    end
  end

  assign res_valid     = (qcnt_r != 2'd0);
  assign pop           = res_valid && res_ready;
  assign res           = q_r[rd_ptr_r];
  assign sts.fifo_full = (qcnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      qcnt_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      qcnt_r <= qcnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/greedy_ctc_decoder_unit.sv -----
// Greedy CTC decoder: one timestep per input transaction, one result per step.
// in_ch  (sink): class_index, probability (Q0.16), last_step.
// out_ch (source): char_valid, dict_index (class - 1), seq_end, confidence.
// cfg_we/cfg_wdata write key_count; write only while the block is idle.
// An ordinary step's result is queued on acceptance. A last step starts a
// restoring divide (one quotient bit per cycle, in the datapath divider) of
// the sum by the count; the divide's result is queued when the queue has room.
// Steps are taken one per cycle while the queue has room, but none from a
// last step's acceptance until its result is queued. Results sit in a two-entry
// queue, so input keeps flowing while a result waits; when out_ch stalls and
// the queue fills, in_ch.ready drops until the receiver takes a transaction.
// Reset (synchronous, active low): key_count returns to 8191, the sequence
// state (previous class, sum, count) clears and the queue empties.
module greedy_ctc_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gctc_pkg::CLASS_W-1:0]  cfg_wdata,
  gctc_in_if.sink                       in_ch,
  gctc_out_if.source                    out_ch
);

  gctc_pkg::gctc_cmd_t cmd;
  gctc_pkg::gctc_sts_t sts;
  gctc_pkg::gctc_res_t res;
  logic                in_ready;

  // controller: accept gating and divide sequencing
  gctc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_step),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: decode, accumulation, divider, result queue
  gctc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .class_index (in_ch.class_index),
    .probability (in_ch.probability),
    .last_step   (in_ch.last_step),
    .cmd         (cmd),
    .sts         (sts),
    .res_valid   (out_ch.valid),
    .res_ready   (out_ch.ready),
    .res         (res)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.char_valid = res.char_valid;
  assign out_ch.dict_index = res.dict_index;
  assign out_ch.seq_end    = res.seq_end;
  assign out_ch.confidence = res.confidence;

endmodule
